// ----- sv/rbc_pkg.sv -----
package rbc_pkg;

  localparam int CFG_BITS       = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CODE_BITS      = 10;
  localparam int OP_BITS        = 2;
  localparam int ACTION_BITS    = 2;

  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_COUNT_BITS  = 8;
  localparam int DEF_RANDOM_BITS = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLED      = 3'd0,
    REG_STABLE       = 3'd1,
    REG_READ_TIMEOUT = 3'd2,
    REG_FIRST_RETRY  = 3'd3,
    REG_BASE_BACKOFF = 3'd4,
    REG_MAX_BACKOFF  = 3'd5
  } cfg_index_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_POLL  = 2'd0,
    OP_ENDED = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE    = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_KILL    = 2'd2
  } action_t;

  localparam logic                RST_ENABLED         = 1'b1;
  localparam logic [CFG_BITS-1:0] RST_STABLE_MS       = CFG_BITS'(60 * 1000);
  localparam logic [CFG_BITS-1:0] RST_READ_TIMEOUT_MS = CFG_BITS'(300 * 1000);
  localparam logic [CFG_BITS-1:0] RST_FIRST_RETRY_MS  = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] RST_BASE_BACKOFF_MS = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] RST_MAX_BACKOFF_MS  = CFG_BITS'(30 * 1000);

  localparam logic [CODE_BITS-1:0] CODE_OK          = CODE_BITS'(200);
  localparam logic [CODE_BITS-1:0] CODE_BAD_REQUEST = CODE_BITS'(400);
  localparam logic [CODE_BITS-1:0] CODE_TIMEOUT     = CODE_BITS'(408);
  localparam logic [CODE_BITS-1:0] CODE_TOO_MANY    = CODE_BITS'(429);
  localparam logic [CODE_BITS-1:0] CODE_SERVER_LO   = CODE_BITS'(500);

  typedef struct packed {
    logic                enabled;
    logic [CFG_BITS-1:0] stable_ms;
    logic [CFG_BITS-1:0] read_timeout_ms;
    logic [CFG_BITS-1:0] first_retry_ms;
    logic [CFG_BITS-1:0] base_backoff_ms;
    logic [CFG_BITS-1:0] max_backoff_ms;
  } cfg_t;

  typedef struct packed {
    logic link_active;
    logic permanent_failure;
    logic waiting;
  } status_t;

endpackage

// ----- sv/rbc_cfg_regs.sv -----
module rbc_cfg_regs
  import rbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output cfg_t                      cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled         <= RST_ENABLED;
      cfg.stable_ms       <= RST_STABLE_MS;
      cfg.read_timeout_ms <= RST_READ_TIMEOUT_MS;
      cfg.first_retry_ms  <= RST_FIRST_RETRY_MS;
      cfg.base_backoff_ms <= RST_BASE_BACKOFF_MS;
      cfg.max_backoff_ms  <= RST_MAX_BACKOFF_MS;
    end else if (wr) begin
      unique case (cfg_index_t'(cfg_index))
        REG_ENABLED:      cfg.enabled         <= cfg_data[0];
        REG_STABLE:       cfg.stable_ms       <= cfg_data;
        REG_READ_TIMEOUT: cfg.read_timeout_ms <= cfg_data;
        REG_FIRST_RETRY:  cfg.first_retry_ms  <= cfg_data;
        REG_BASE_BACKOFF: cfg.base_backoff_ms <= cfg_data;
        REG_MAX_BACKOFF:  cfg.max_backoff_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/rbc_backoff.sv -----
module rbc_backoff
  import rbc_pkg::*;
#(
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int RANDOM_BITS = DEF_RANDOM_BITS
) (
  input  logic [COUNT_BITS-1:0]  attempts,
  input  cfg_t                   cfg,
  input  logic [RANDOM_BITS-1:0] random_value,
  output logic [CFG_BITS-1:0]    retry_ms
);

  localparam int SHIFT_BITS = $clog2(CFG_BITS);
  localparam int HALF_BITS  = CFG_BITS - 1;
  localparam int PROD_BITS  = HALF_BITS + RANDOM_BITS;

  logic [COUNT_BITS-1:0]   shift;
  logic [SHIFT_BITS-1:0]   shift_amt;
  logic                    far;
  logic [2*CFG_BITS-1:0]   shifted;
  logic [CFG_BITS-1:0]     full;
  logic [HALF_BITS-1:0]    half;
  logic [PROD_BITS-1:0]    product;
  logic [HALF_BITS-1:0]    jitter;

  assign shift     = attempts - COUNT_BITS'(1);
  assign far       = 32'(shift) >= 32'(CFG_BITS);
  assign shift_amt = SHIFT_BITS'(shift);
  assign shifted   = (2*CFG_BITS)'(cfg.base_backoff_ms) << shift_amt;

  // exponential term capped at the maximum
  always_comb begin
    priority if (cfg.base_backoff_ms == '0) begin
      full = '0;
    end else if (far || shifted > (2*CFG_BITS)'(cfg.max_backoff_ms)) begin
      full = cfg.max_backoff_ms;
    end else begin
      full = shifted[CFG_BITS-1:0];
    end
  end

  assign half     = full[CFG_BITS-1:1];
  assign product  = PROD_BITS'(half) * PROD_BITS'(random_value);
  assign jitter   = product[PROD_BITS-1:RANDOM_BITS];
  assign retry_ms = {1'b0, half} + {1'b0, jitter};

endmodule

// ----- sv/rbc_engine.sv -----
module rbc_engine
  import rbc_pkg::*;
#(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int RANDOM_BITS = DEF_RANDOM_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [OP_BITS-1:0]     opcode,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [CODE_BITS-1:0]   response_code,
  input  logic [RANDOM_BITS-1:0] random_value,
  input  cfg_t                   cfg,
  output action_t                res_action,
  output logic [COUNT_BITS-1:0]  res_attempts,
  output logic                   res_failed,
  output logic                   res_waiting,
  output status_t                status
);

  logic                  link_active, link_active_next;
  logic                  permanent_failure, permanent_failure_next;
  logic [COUNT_BITS-1:0] attempts, attempts_next;
  logic [TIME_BITS-1:0]  wait_deadline, wait_deadline_next;
  logic [TIME_BITS-1:0]  started_time, started_time_next;
  logic [TIME_BITS-1:0]  last_read_time, last_read_time_next;

  logic                  stable;
  logic                  timed_out;
  logic [COUNT_BITS-1:0] bumped;
  logic                  perm_code;
  logic [CFG_BITS-1:0]   backoff_ms;
  logic [CFG_BITS-1:0]   retry_ms;
  logic [TIME_BITS-1:0]  deadline_add;

  rbc_backoff #(
    .COUNT_BITS  (COUNT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_backoff (
    .attempts     (attempts),
    .cfg          (cfg),
    .random_value (random_value),
    .retry_ms     (backoff_ms)
  );

  assign stable = (now_ms >= started_time) &&
                  ((now_ms - started_time) >= TIME_BITS'(cfg.stable_ms));
  assign timed_out = (now_ms >= last_read_time) &&
                     ((now_ms - last_read_time) >= TIME_BITS'(cfg.read_timeout_ms));
  assign bumped = (attempts == '1) ? attempts : attempts + COUNT_BITS'(1);
  assign perm_code = (response_code >= CODE_BAD_REQUEST) &&
                     (response_code < CODE_SERVER_LO) &&
                     (response_code != CODE_BAD_REQUEST) &&
                     (response_code != CODE_TIMEOUT) &&
                     (response_code != CODE_TOO_MANY);
  assign retry_ms = (attempts == COUNT_BITS'(1)) ? cfg.first_retry_ms : backoff_ms;
  assign deadline_add = now_ms + TIME_BITS'(retry_ms);

  always_comb begin
    link_active_next       = link_active;
    permanent_failure_next = permanent_failure;
    attempts_next          = attempts;
    wait_deadline_next     = wait_deadline;
    started_time_next      = started_time;
    last_read_time_next    = last_read_time;
    res_action             = ACT_NONE;
    unique case (opcode_t'(opcode))
      OP_POLL: begin
        if (cfg.enabled && !permanent_failure) begin
          priority if (link_active) begin
            if (timed_out) begin
              link_active_next = 1'b0;
              attempts_next    = bumped;
              res_action       = ACT_KILL;
            end
          end else if (attempts != '0 && wait_deadline == '0) begin
            wait_deadline_next = deadline_add;
          end else if (attempts == '0 || now_ms >= wait_deadline) begin
            if (attempts != '0) begin
              wait_deadline_next = '0;
              started_time_next  = now_ms;
            end
            link_active_next    = 1'b1;
            last_read_time_next = now_ms;
            res_action          = ACT_CONNECT;
          end else begin
            // deadline not reached yet
            res_action = ACT_NONE;
          end
        end
      end
      OP_ENDED: begin
        link_active_next = 1'b0;
        if (response_code == CODE_OK) begin
          attempts_next = stable ? '0 : bumped;
        end else begin
          if (perm_code) begin
            permanent_failure_next = 1'b1;
          end
          attempts_next = bumped;
        end
      end
      OP_READ: begin
        last_read_time_next = now_ms;
      end
      default: ;
    endcase
  end

  assign res_attempts = attempts_next;
  assign res_failed   = permanent_failure_next;
  assign res_waiting  = wait_deadline_next != '0;

  assign status.link_active       = link_active;
  assign status.permanent_failure = permanent_failure;
  assign status.waiting           = wait_deadline != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_active       <= 1'b0;
      permanent_failure <= 1'b0;
      attempts          <= '0;
      wait_deadline     <= '0;
      started_time      <= '0;
      last_read_time    <= '0;
    end else if (fire) begin
      link_active       <= link_active_next;
      permanent_failure <= permanent_failure_next;
      attempts          <= attempts_next;
      wait_deadline     <= wait_deadline_next;
      started_time      <= started_time_next;
      last_read_time    <= last_read_time_next;
    end
  end

endmodule

// ----- sv/reconnect_backoff_controller_core.sv -----
// Reconnect backoff controller.
// Input channel (in_valid/in_ready) carries one event item: a poll tick, a
// connection that ended with a response code, or data read. Each item gives
// exactly one result item on the output channel (out_valid/out_ready): the
// action to take (none, start connection, kill stalled stream), the attempt
// count, the permanent-failure flag and whether a retry deadline is pending.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per item; write it only while idle.
// An accepted item sits in the input register, is evaluated against the link
// state and lands in the result register, which raises out_valid. Throughput
// is one item per cycle while the receiver keeps out_ready high, set by the
// single state update in the event stage.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; in_ready drops only when both are full.
// Synchronous reset empties both registers, clears the link state (inactive,
// no failure, zero attempts, no deadline, zero times) and loads the
// configuration defaults: enabled, 60 s stable, 300 s read timeout, 1 s first
// retry, 1 s backoff unit, 30 s cap.
module reconnect_backoff_controller_core
  import rbc_pkg::*;
#(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int RANDOM_BITS = DEF_RANDOM_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_BITS-1:0]        opcode,
  input  logic [TIME_BITS-1:0]      now_ms,
  input  logic [CODE_BITS-1:0]      response_code,
  input  logic [RANDOM_BITS-1:0]    random_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ACTION_BITS-1:0]    action,
  output logic [COUNT_BITS-1:0]     attempt_count,
  output logic                      failed_for_good,
  output logic                      waiting,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  cfg_t                   cfg;
  status_t                status;

  logic                   s1_valid;
  logic [OP_BITS-1:0]     s1_opcode;
  logic [TIME_BITS-1:0]   s1_now;
  logic [CODE_BITS-1:0]   s1_code;
  logic [RANDOM_BITS-1:0] s1_random;
  logic                   s1_fire;
  logic                   in_fire;

  action_t                res_action;
  logic [COUNT_BITS-1:0]  res_attempts;
  logic                   res_failed;
  logic                   res_waiting;

  rbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= opcode;
      s1_now    <= now_ms;
      s1_code   <= response_code;
      s1_random <= random_value;
    end
  end

  rbc_engine #(
    .TIME_BITS   (TIME_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_fire),
    .opcode        (s1_opcode),
    .now_ms        (s1_now),
    .response_code (s1_code),
    .random_value  (s1_random),
    .cfg           (cfg),
    .res_action    (res_action),
    .res_attempts  (res_attempts),
    .res_failed    (res_failed),
    .res_waiting   (res_waiting),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      action          <= res_action;
      attempt_count   <= res_attempts;
      failed_for_good <= res_failed;
      waiting         <= res_waiting;
    end
  end

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    $past(s1_fire) && !$past(rst) |-> out_valid)
    else $error("evaluated item did not reach the result register");

  a_failure_sticks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(status.permanent_failure) |-> status.permanent_failure)
    else $error("permanent failure cleared without reset");

  a_kill_drops_link: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_action == ACT_KILL |=> !status.link_active)
    else $error("link still active after kill");

  a_connect_raises_link: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_action == ACT_CONNECT |=> status.link_active)
    else $error("link not active after connect");
`endif

endmodule

// ----- tb/sv/reconnect_backoff_controller_core_tb.sv -----
module reconnect_backoff_controller_core_tb;
  import rbc_pkg::*;

  localparam int TB_TIME_BITS  = DEF_TIME_BITS;
  localparam int TB_COUNT_BITS = DEF_COUNT_BITS;
  localparam int TB_RAND_BITS  = DEF_RANDOM_BITS;

  localparam logic [OP_BITS-1:0]   OP_UNUSED         = 2'd3;
  localparam logic [CODE_BITS-1:0] CODE_NONE         = 10'd0;
  localparam logic [CODE_BITS-1:0] CODE_UNAUTHORIZED = 10'd401;
  localparam logic [CODE_BITS-1:0] CODE_NOT_FOUND    = 10'd404;
  localparam logic [CODE_BITS-1:0] CODE_CLIENT_TOP   = 10'd499;
  localparam logic [CODE_BITS-1:0] CODE_TOP          = 10'd999;
  localparam logic [CFG_BITS-1:0]  CFG_FULL          = '1;
  localparam logic [TB_COUNT_BITS-1:0] COUNT_SAT     = '1;

  typedef struct packed {
    action_t                  act;
    logic [TB_COUNT_BITS-1:0] cnt;
    logic                     dead;
    logic                     pending;
  } outcome_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_BITS-1:0]       opcode;
  logic [TB_TIME_BITS-1:0]  now_ms;
  logic [CODE_BITS-1:0]     response_code;
  logic [TB_RAND_BITS-1:0]  random_value;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ACTION_BITS-1:0]   action;
  logic [TB_COUNT_BITS-1:0] attempt_count;
  logic                     failed_for_good;
  logic                     waiting;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]      cfg_data;

  // predictor copy of registers and link state
  logic                     cfg_en;
  logic [CFG_BITS-1:0]      cfg_stable;
  logic [CFG_BITS-1:0]      cfg_read_to;
  logic [CFG_BITS-1:0]      cfg_first;
  logic [CFG_BITS-1:0]      cfg_base;
  logic [CFG_BITS-1:0]      cfg_max;
  logic                     link_up;
  logic                     hard_fail;
  logic [TB_COUNT_BITS-1:0] fail_count;
  logic [TB_TIME_BITS-1:0]  retry_at;
  logic [TB_TIME_BITS-1:0]  conn_start;
  logic [TB_TIME_BITS-1:0]  last_data;

  outcome_t pending_outcomes[$];
  logic [TB_TIME_BITS-1:0] wall_ms;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int item_count = 0;
  int checked_count = 0;
  int connect_count = 0;
  int kill_count = 0;
  int peak_attempts = 0;

  reconnect_backoff_controller_core uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .now_ms          (now_ms),
    .response_code   (response_code),
    .random_value    (random_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .attempt_count   (attempt_count),
    .failed_for_good (failed_for_good),
    .waiting         (waiting),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit span_passed(logic [TB_TIME_BITS-1:0] since, logic [CFG_BITS-1:0] span,
                                     logic [TB_TIME_BITS-1:0] now);
    return (now >= since) && ((now - since) >= TB_TIME_BITS'(span));
  endfunction

  function automatic void end_connection(logic [CODE_BITS-1:0] code,
                                         logic [TB_TIME_BITS-1:0] now);
    link_up = 1'b0;
    if (code == CODE_OK && span_passed(conn_start, cfg_stable, now)) begin
      fail_count = '0;
    end else begin
      if (code >= CODE_BAD_REQUEST && code < CODE_SERVER_LO && code != CODE_BAD_REQUEST &&
          code != CODE_TIMEOUT && code != CODE_TOO_MANY)
        hard_fail = 1'b1;
      if (fail_count != COUNT_SAT)
        fail_count = fail_count + TB_COUNT_BITS'(1);
    end
  endfunction

  function automatic logic [63:0] backoff_wait(logic [TB_RAND_BITS-1:0] rnd);
    logic [63:0] shift;
    logic [63:0] full;
    logic [63:0] half;
    shift = 64'(fail_count) - 64'd1;
    if (cfg_base == '0) begin
      full = '0;
    end else if (shift >= 64'(CFG_BITS)) begin
      full = 64'(cfg_max);
    end else begin
      full = 64'(cfg_base) << shift;
      if (full > 64'(cfg_max))
        full = 64'(cfg_max);
    end
    half = full >> 1;
    return half + ((half * 64'(rnd)) >> TB_RAND_BITS);
  endfunction

  function automatic action_t poll_event(logic [TB_TIME_BITS-1:0] now,
                                         logic [TB_RAND_BITS-1:0] rnd);
    logic [TB_TIME_BITS-1:0] delay;
    if (!cfg_en || hard_fail)
      return ACT_NONE;
    if (link_up) begin
      if (span_passed(last_data, cfg_read_to, now)) begin
        end_connection(CODE_NONE, now);
        return ACT_KILL;
      end
      return ACT_NONE;
    end
    if (fail_count != '0) begin
      if (retry_at != '0) begin
        if (now < retry_at)
          return ACT_NONE;
        retry_at = '0;
        conn_start = now;
      end else begin
        delay = (fail_count == TB_COUNT_BITS'(1)) ? TB_TIME_BITS'(cfg_first) :
                                                    TB_TIME_BITS'(backoff_wait(rnd));
        retry_at = now + delay;
        return ACT_NONE;
      end
    end
    link_up = 1'b1;
    last_data = now;
    return ACT_CONNECT;
  endfunction

  function automatic outcome_t next_outcome(logic [OP_BITS-1:0] op,
                                            logic [TB_TIME_BITS-1:0] now,
                                            logic [CODE_BITS-1:0] code,
                                            logic [TB_RAND_BITS-1:0] rnd);
    outcome_t r;
    r.act = ACT_NONE;
    case (op)
      OP_POLL:  r.act = poll_event(now, rnd);
      OP_ENDED: end_connection(code, now);
      OP_READ:  last_data = now;
      default: ;
    endcase
    r.cnt = fail_count;
    r.dead = hard_fail;
    r.pending = (retry_at != '0);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      cfg_en      = RST_ENABLED;
      cfg_stable  = RST_STABLE_MS;
      cfg_read_to = RST_READ_TIMEOUT_MS;
      cfg_first   = RST_FIRST_RETRY_MS;
      cfg_base    = RST_BASE_BACKOFF_MS;
      cfg_max     = RST_MAX_BACKOFF_MS;
      link_up     = 1'b0;
      hard_fail   = 1'b0;
      fail_count  = '0;
      retry_at    = '0;
      conn_start  = '0;
      last_data   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED:      cfg_en = cfg_data[0];
          REG_STABLE:       cfg_stable = cfg_data;
          REG_READ_TIMEOUT: cfg_read_to = cfg_data;
          REG_FIRST_RETRY:  cfg_first = cfg_data;
          REG_BASE_BACKOFF: cfg_base = cfg_data;
          REG_MAX_BACKOFF:  cfg_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = next_outcome(opcode, now_ms, response_code, random_value);
        pending_outcomes.push_back(want);
        item_count++;
        if (want.act == ACT_CONNECT)
          connect_count++;
        if (want.act == ACT_KILL)
          kill_count++;
        if (int'(want.cnt) > peak_attempts)
          peak_attempts = int'(want.cnt);
      end
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result item with nothing expected: action %0d", action);
          err_count++;
        end else begin
          want = pending_outcomes.pop_front();
          checked_count++;
          if (action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, action);
            err_count++;
          end
          if (attempt_count !== want.cnt) begin
            $error("attempt_count: expected %0d, got %0d", want.cnt, attempt_count);
            err_count++;
          end
          if (failed_for_good !== want.dead) begin
            $error("failed_for_good: expected %0d, got %0d", want.dead, failed_for_good);
            err_count++;
          end
          if (waiting !== want.pending) begin
            $error("waiting: expected %0d, got %0d", want.pending, waiting);
            err_count++;
          end
        end
      end
    end
  end

  task automatic send_event(logic [OP_BITS-1:0] op, logic [TB_TIME_BITS-1:0] now,
                            logic [CODE_BITS-1:0] code, logic [TB_RAND_BITS-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    now_ms        <= now;
    response_code <= code;
    random_value  <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic en, logic [CFG_BITS-1:0] stable, logic [CFG_BITS-1:0] rto,
                                logic [CFG_BITS-1:0] first, logic [CFG_BITS-1:0] base,
                                logic [CFG_BITS-1:0] cap);
    wait_idle();
    write_reg(REG_ENABLED, CFG_BITS'(en));
    write_reg(REG_STABLE, stable);
    write_reg(REG_READ_TIMEOUT, rto);
    write_reg(REG_FIRST_RETRY, first);
    write_reg(REG_BASE_BACKOFF, base);
    write_reg(REG_MAX_BACKOFF, cap);
  endtask

  function automatic logic [CODE_BITS-1:0] pick_code(bit allow_ok);
    case ($urandom_range(0, 7))
      0, 1:    return allow_ok ? CODE_OK : CODE_SERVER_LO;
      2:       return CODE_NONE;
      3:       return CODE_BAD_REQUEST;
      4:       return CODE_TIMEOUT;
      5:       return CODE_TOO_MANY;
      6:       return CODE_BITS'($urandom_range(0, 399));
      default: return CODE_BITS'($urandom_range(500, 999));
    endcase
  endfunction

  task automatic advance_clock(int unsigned span);
    case ($urandom_range(0, 39))
      0:       wall_ms = TB_TIME_BITS'({$urandom, $urandom});
      1, 2:    wall_ms = wall_ms - TB_TIME_BITS'($urandom_range(0, span));
      3, 4, 5: ;
      default: wall_ms = wall_ms + TB_TIME_BITS'($urandom_range(0, span));
    endcase
  endtask

  task automatic run_traffic(int count, int unsigned span, int end_pct, bit allow_ok);
    int sel;
    repeat (count) begin
      advance_clock(span);
      sel = $urandom_range(99);
      if (sel < end_pct)
        send_event(OP_ENDED, wall_ms, pick_code(allow_ok), TB_RAND_BITS'($urandom));
      else if (sel < end_pct + 12)
        send_event(OP_READ, wall_ms, CODE_BITS'($urandom_range(0, 999)),
                   TB_RAND_BITS'($urandom));
      else if (sel < end_pct + 14)
        send_event(OP_UNUSED, wall_ms, CODE_BITS'($urandom_range(0, 999)),
                   TB_RAND_BITS'($urandom));
      else
        send_event(OP_POLL, wall_ms, CODE_BITS'($urandom_range(0, 999)),
                   TB_RAND_BITS'($urandom));
    end
  endtask

  // connect, silence kill, first retry, backoff with jitter extremes, clean close
  task automatic test_lifecycle();
    wall_ms = 48'd1000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    wall_ms = wall_ms + 48'd1000;
    send_event(OP_READ, wall_ms, CODE_NONE, 16'hFFFF);
    send_event(OP_POLL, wall_ms + 48'd299_999, CODE_NONE, 16'h0000);
    wall_ms = wall_ms + 48'd300_000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms + 48'd999, CODE_NONE, 16'h0000);
    wall_ms = wall_ms + 48'd1000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_ENDED, wall_ms + 48'd59_999, CODE_OK, 16'h0000);
    wall_ms = wall_ms + 48'd60_000;
    send_event(OP_ENDED, wall_ms, CODE_SERVER_LO, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    wall_ms = wall_ms + 48'd2000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_ENDED, wall_ms + 48'd60_000, CODE_OK, 16'h0000);
    send_event(OP_UNUSED, '1, CODE_TOP, '1);
    wall_ms = wall_ms + 48'd70_000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_READ, '1, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms + 48'd1, CODE_NONE, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_TIMEOUT, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_TOO_MANY, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_BAD_REQUEST, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_TOP, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'hFFFF);
  endtask

  // disable, zero stable time, deadline wrap to zero, all-zero and all-max registers
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_ENABLED, '0);
    wall_ms = wall_ms + 48'd1_000_000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    wait_idle();
    write_reg(REG_ENABLED, CFG_BITS'(1));
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    wait_idle();
    write_reg(REG_STABLE, '0);
    send_event(OP_ENDED, wall_ms, CODE_OK, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_SERVER_LO, 16'h0000);
    send_event(OP_POLL, 48'hFFFF_FFFF_FC18, CODE_NONE, 16'h0000);
    send_event(OP_POLL, '1, CODE_NONE, 16'h0000);
    send_event(OP_POLL, '1, CODE_NONE, 16'h0000);
    apply_settings(1'b1, '0, '0, '0, '0, '0);
    wall_ms = 48'd5000;
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_READ, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_SERVER_LO, 16'h0000);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'hFFFF);
    apply_settings(1'b1, CFG_FULL, CFG_FULL, CFG_FULL, CFG_FULL, CFG_FULL);
    send_event(OP_POLL, wall_ms, CODE_NONE, 16'hFFFF);
  endtask

  task automatic test_short_timer_traffic();
    apply_settings(1'b1, 24'd2000, 24'd5000, 24'd300, 24'd100, 24'd4000);
    run_traffic(380, 6000, 22, 1'b1);
  endtask

  task automatic test_extreme_timer_traffic();
    apply_settings(1'b1, '0, '0, '0, '0, '0);
    run_traffic(180, 50, 22, 1'b1);
    apply_settings(1'b1, CFG_FULL, CFG_FULL, CFG_FULL, CFG_FULL, CFG_FULL);
    run_traffic(180, 32'h0200_0000, 22, 1'b1);
  endtask

  task automatic test_default_traffic();
    apply_settings(RST_ENABLED, RST_STABLE_MS, RST_READ_TIMEOUT_MS, RST_FIRST_RETRY_MS,
                   RST_BASE_BACKOFF_MS, RST_MAX_BACKOFF_MS);
    run_traffic(260, 70_000, 22, 1'b1);
  endtask

  // long failure run drives the count into saturation and the shift past the cap
  task automatic test_attempt_saturation();
    apply_settings(1'b1, CFG_FULL, CFG_FULL, 24'd50, 24'd1, CFG_FULL);
    run_traffic(280, 200, 90, 1'b0);
    run_traffic(20, 32'h0200_0000, 10, 1'b0);
  endtask

  task automatic test_permanent_failure();
    apply_settings(1'b1, 24'd100, 24'd100, 24'd10, 24'd10, 24'd1000);
    wall_ms = wall_ms + 48'd1000;
    send_event(OP_ENDED, wall_ms, CODE_NOT_FOUND, 16'h0000);
    send_event(OP_POLL, wall_ms + 48'd100_000, CODE_NONE, 16'h0000);
    send_event(OP_READ, wall_ms, CODE_NONE, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_UNAUTHORIZED, 16'h0000);
    send_event(OP_ENDED, wall_ms, CODE_CLIENT_TOP, 16'h0000);
    run_traffic(20, 5000, 20, 1'b1);
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    opcode        <= OP_POLL;
    now_ms        <= '0;
    response_code <= '0;
    random_value  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_ENABLED;
    cfg_data      <= '0;
    wall_ms       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 46;
    test_lifecycle();
    test_register_extremes();
    test_short_timer_traffic();

    send_idle_pct = 46;
    recv_idle_pct = 30;
    test_extreme_timer_traffic();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_default_traffic();
    test_attempt_saturation();
    test_permanent_failure();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d event items and %0d checked results", item_count, checked_count);
    $display("link starts %0d, stream kills %0d, peak attempt count %0d",
             connect_count, kill_count, peak_attempts);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
